@@ rtl/rlc_rx_pkg.sv @@
// Shared types and constants for the RLC AM receive reassembler.
package rlc_rx_pkg;

   typedef struct packed {
      logic        mode;
      logic [15:0] rnti;
      logic [4:0]  lc_id;
      logic [13:0] pdu_length;
      logic [7:0]  header_byte0;
      logic [7:0]  header_byte1;
      logic [7:0]  header_byte2;
   } req_type;

   typedef struct packed {
      logic [3:0]  outcome;
      logic [15:0] out_rnti;
      logic [4:0]  out_lc_id;
      logic [19:0] sdu_length;
      logic        partial_discarded;
   } rsp_type;

   localparam logic [3:0] OC_DELIVERED  = 4'd0;
   localparam logic [3:0] OC_HELD       = 4'd1;
   localparam logic [3:0] OC_NO_DATA    = 4'd2;
   localparam logic [3:0] OC_NOT_AM     = 4'd3;
   localparam logic [3:0] OC_BAD_HEADER = 4'd4;
   localparam logic [3:0] OC_STATUS     = 4'd5;
   localparam logic [3:0] OC_SEGMENT    = 4'd6;
   localparam logic [3:0] OC_NO_SLOT    = 4'd7;
   localparam logic [3:0] OC_BAD_FI     = 4'd8;
   localparam logic [3:0] OC_RELEASED   = 4'd9;
   localparam logic [3:0] OC_UNKNOWN_UE = 4'd10;

   localparam logic [1:0] FI_FULL  = 2'd0;
   localparam logic [1:0] FI_START = 2'd1;
   localparam logic [1:0] FI_END   = 2'd2;
   localparam logic [1:0] FI_MID   = 2'd3;

   localparam logic [1:0]  MAX_AM_RESET = 2'd2;
   localparam logic [19:0] LEN_MAX      = 20'hFFFFF;
   localparam logic [13:0] HDR_BYTES    = 14'd2;
   localparam logic [13:0] RF_MIN_LEN   = 14'd4;

endpackage

@@ rtl/rlc_am_rx_sdu_reassembler_core.sv @@
// Top level of the RLC AM receive reassembler: slot lookup, held-SDU table, result register.
//
// Each transfer on the request channel is one PDU descriptor or a UE release and yields exactly
// one result. In the accept cycle the rnti is matched against the UE slot table and the
// held-SDU memory (one synchronous port, registered read) is read at slot * AM_CHANNELS_PER_UE
// + lc_id (lc_id 0 when it is out of range); in the execute state the entry is updated, written back
// and the result is loaded into the output register. The next request is accepted only once the
// block is idle again, so a new item is not taken before the last result is committed; a stalled
// result holds the block in its execute state. The held-SDU memory needs no clearing pass: per-entry
// valid bits clear at reset, and a new or released UE clears its row of valid bits at once.
module rlc_am_rx_sdu_reassembler_core
   import rlc_rx_pkg::*;
#(
   parameter int UE_SLOTS           = 16,
   parameter int AM_CHANNELS_PER_UE = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data
);

   localparam int ENTRIES = UE_SLOTS * AM_CHANNELS_PER_UE;
   localparam int SLOT_W  = (UE_SLOTS > 1) ? $clog2(UE_SLOTS) : 1;
   localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   typedef struct packed {
      logic [9:0]  sn;
      logic [19:0] length;
   } held_type;

   state_type             state_ff, state_in;
   req_type               req_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic                  hit_ff;
   logic                  free_ok_ff;
   logic [ENTRY_W-1:0]    addr_ff;
   logic [1:0]            max_am_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff;
   logic [UE_SLOTS-1:0]   slot_used_ff, slot_used_in;
   logic [ENTRIES-1:0]    held_valid_ff, held_valid_in;
   logic [15:0]           slot_rnti_ff [UE_SLOTS];
   held_type              held_mem [ENTRIES];
   held_type              held_rd_ff;

   logic                  accept;
   logic                  commit;
   logic                  look_hit;
   logic                  look_free;
   logic [SLOT_W-1:0]     hit_idx;
   logic [SLOT_W-1:0]     free_idx;
   logic [SLOT_W-1:0]     slot_sel;
   logic [4:0]            lc_sel;
   logic [ENTRY_W-1:0]    rd_addr;

   logic                  rnti_we;
   logic                  mem_we;
   held_type              mem_wdata;
   rsp_type               rsp_new;
   logic [3:0]            oc;
   logic [19:0]           len;
   logic                  disc;
   logic                  row_any;
   logic                  clear_row;
   logic                  hv;
   logic                  cont;
   logic                  keep_going;
   logic [9:0]            sn;
   logic [1:0]            fi;
   logic [13:0]           size;
   logic [20:0]           sum;
   logic [19:0]           sum_sat;
   logic                  not_am;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign commit    = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // slot lookup on the incoming rnti
   always_comb begin
      look_hit  = 1'b0;
      look_free = 1'b0;
      hit_idx   = '0;
      free_idx  = '0;
      for (int k = 0; k < UE_SLOTS; k++) begin
         if (slot_used_ff[k] && (slot_rnti_ff[k] == req_data.rnti)) begin
            look_hit = 1'b1;
            hit_idx  = SLOT_W'(k);
         end
      end
      for (int k = UE_SLOTS - 1; k >= 0; k--) begin
         if (!slot_used_ff[k]) begin
            look_free = 1'b1;
            free_idx  = SLOT_W'(k);
         end
      end
      slot_sel = look_hit ? hit_idx : free_idx;
      lc_sel   = (32'(req_data.lc_id) < AM_CHANNELS_PER_UE) ? req_data.lc_id : 5'd0;
      rd_addr  = ENTRY_W'(32'(slot_sel) * AM_CHANNELS_PER_UE + 32'(lc_sel));
   end

   // decode, reassemble and build the result
   always_comb begin
      oc            = OC_NOT_AM;
      len           = '0;
      disc          = 1'b0;
      rnti_we       = 1'b0;
      mem_we        = 1'b0;
      clear_row     = 1'b0;
      slot_used_in  = slot_used_ff;
      held_valid_in = held_valid_ff;
      sn            = {req_ff.header_byte0[1:0], req_ff.header_byte1};
      fi            = req_ff.header_byte0[4:3];
      size          = req_ff.pdu_length - HDR_BYTES;
      sum           = {1'b0, held_rd_ff.length} + 21'(size);
      sum_sat       = sum[20] ? LEN_MAX : sum[19:0];
      hv            = hit_ff && held_valid_ff[addr_ff];
      cont          = (sn == held_rd_ff.sn) || (sn == held_rd_ff.sn + 10'd1);
      keep_going    = hv && cont && ((fi == FI_END) || (fi == FI_MID));
      mem_wdata     = held_rd_ff;
      not_am        = (req_ff.lc_id > {3'b000, max_am_ff})
                      || (32'(req_ff.lc_id) >= AM_CHANNELS_PER_UE);
      row_any       = 1'b0;
      for (int c = 0; c < AM_CHANNELS_PER_UE; c++) begin
         row_any = row_any
                   || held_valid_ff[ENTRY_W'(32'(slot_ff) * AM_CHANNELS_PER_UE + c)];
      end

      if (req_ff.mode) begin
         if (hit_ff) begin
            oc                    = OC_RELEASED;
            disc                  = row_any;
            clear_row             = 1'b1;
            slot_used_in[slot_ff] = 1'b0;
         end else begin
            oc = OC_UNKNOWN_UE;
         end
      end else if (not_am) begin
         oc = OC_NOT_AM;
      end else if (req_ff.pdu_length == 14'd0) begin
         oc = OC_NO_DATA;
      end else if (req_ff.pdu_length < HDR_BYTES) begin
         oc = OC_BAD_HEADER;
      end else if (!req_ff.header_byte0[7]) begin
         oc = OC_STATUS;
      end else if (req_ff.header_byte0[6] && (req_ff.pdu_length < RF_MIN_LEN)) begin
         oc = OC_BAD_HEADER;
      end else if (!hit_ff && !free_ok_ff) begin
         oc = OC_NO_SLOT;
      end else begin
         if (!hit_ff) begin
            rnti_we               = 1'b1;
            clear_row             = 1'b1;
            slot_used_in[slot_ff] = 1'b1;
         end
         if (req_ff.header_byte0[6]) begin
            oc = OC_SEGMENT;
         end else if (req_ff.header_byte0[2]) begin
            oc = OC_BAD_HEADER;
         end else if (keep_going) begin
            if (fi == FI_END) begin
               oc                     = OC_DELIVERED;
               len                    = sum_sat;
               held_valid_in[addr_ff] = 1'b0;
            end else begin
               oc        = OC_HELD;
               mem_we    = 1'b1;
               mem_wdata = '{sn: sn, length: sum_sat};
            end
         end else begin
            disc                   = hv;
            held_valid_in[addr_ff] = 1'b0;
            case (fi)
               FI_FULL: begin
                  oc  = OC_DELIVERED;
                  len = 20'(size);
               end
               FI_START: begin
                  oc                     = OC_HELD;
                  mem_we                 = 1'b1;
                  mem_wdata              = '{sn: sn, length: 20'(size)};
                  held_valid_in[addr_ff] = 1'b1;
               end
               default: oc = OC_BAD_FI;
            endcase
         end
      end

      if (clear_row) begin
         for (int c = 0; c < AM_CHANNELS_PER_UE; c++) begin
            held_valid_in[ENTRY_W'(32'(slot_ff) * AM_CHANNELS_PER_UE + c)] = 1'b0;
         end
         if (!req_ff.mode && !req_ff.header_byte0[6] && !req_ff.header_byte0[2]
             && !keep_going && (fi == FI_START)) begin
            held_valid_in[addr_ff] = 1'b1;
         end
      end

      rsp_new.outcome           = oc;
      rsp_new.out_rnti          = req_ff.rnti;
      rsp_new.out_lc_id         = req_ff.mode ? 5'd0 : req_ff.lc_id;
      rsp_new.sdu_length        = (oc == OC_DELIVERED) ? len : 20'd0;
      rsp_new.partial_discarded = disc;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         max_am_ff     <= MAX_AM_RESET;
         slot_used_ff  <= '0;
         held_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            max_am_ff <= csr_write_data;
         end
         if (commit) begin
            slot_used_ff  <= slot_used_in;
            held_valid_ff <= held_valid_in;
         end
      end
      if (accept) begin
         req_ff     <= req_data;
         slot_ff    <= slot_sel;
         hit_ff     <= look_hit;
         free_ok_ff <= look_free;
         addr_ff    <= rd_addr;
      end
      if (commit) begin
         rsp_data_ff <= rsp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && rnti_we) begin
         slot_rnti_ff[slot_ff] <= req_ff.rnti;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_rd_ff <= held_mem[rd_addr];
      end
      if (commit && mem_we) begin
         held_mem[addr_ff] <= mem_wdata;
      end
   end

endmodule
